>>> hw/rtl/trilinear_interpolator_unit_macros.svh
// ----------------------------------------------------------------------------
// Trilinear interpolator assertion macros
// Shared property forms for the port checker, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef TRILINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define TRILINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define TIU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TIU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tiu_pkg.sv
// ----------------------------------------------------------------------------
// Trilinear interpolator package
// Pipeline depth and lane count constants, and the merge-stage enable group.
// ----------------------------------------------------------------------------
`default_nettype none

package tiu_pkg;

    localparam int LERP_STAGES = 3;
    localparam int X_LANES     = 4;

    typedef struct packed {
        logic [LERP_STAGES-1:0] y_en;
        logic [LERP_STAGES-1:0] z_en;
    } merge_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/tiu_lerp.sv
// ----------------------------------------------------------------------------
// Trilinear interpolator lerp lane
// Three-stage a + round((b - a) * f / 2^FRAC_BITS): difference, product, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tiu_lerp #(
    parameter int VALUE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                                      clk,
    input  wire logic [tiu_pkg::LERP_STAGES-1:0]     en,
    input  wire logic signed [VALUE_BITS-1:0]        a,
    input  wire logic signed [VALUE_BITS-1:0]        b,
    input  wire logic [FRAC_BITS:0]                  f,
    output logic signed [VALUE_BITS-1:0]             y
);

    localparam int DW = VALUE_BITS + 1;
    localparam int FW = FRAC_BITS + 1;
    localparam int PW = DW + FW;
    localparam logic [PW:0] HALF = {{(PW + 1 - FRAC_BITS){1'b0}}, 1'b1,
                                    {(FRAC_BITS - 1){1'b0}}};

    logic signed [DW-1:0]         d_reg, d_next;
    logic signed [VALUE_BITS-1:0] a1_reg, a2_reg;
    logic [FW-1:0]                f1_reg;
    logic signed [FW:0]           f_sgn;
    logic signed [PW:0]           prod_reg, prod_next;
    logic [PW:0]                  a_ext;
    logic [PW:0]                  sum;
    logic signed [VALUE_BITS-1:0] y_reg, y_next;

    assign d_next = {b[VALUE_BITS-1], b} - {a[VALUE_BITS-1], a};

    assign f_sgn     = {1'b0, f1_reg};
    assign prod_next = d_reg * f_sgn;

    assign a_ext  = {{(PW + 1 - VALUE_BITS){a2_reg[VALUE_BITS-1]}}, a2_reg};
    assign sum    = (a_ext << FRAC_BITS) + prod_reg + HALF;
    assign y_next = sum[FRAC_BITS +: VALUE_BITS];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg  <= d_next;
            a1_reg <= a;
            f1_reg <= f;
        end
        if (en[1])
        begin
            prod_reg <= prod_next;
            a2_reg   <= a1_reg;
        end
        if (en[2])
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tiu_merge.sv
// ----------------------------------------------------------------------------
// Trilinear interpolator merge stage
// Blend the four x-lane results along y with two lerps, then along z with one.
// ----------------------------------------------------------------------------
`default_nettype none

module tiu_merge #(
    parameter int VALUE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                                  clk,
    input  wire tiu_pkg::merge_ctl_t             ctl,
    input  wire logic signed [VALUE_BITS-1:0]    x00,
    input  wire logic signed [VALUE_BITS-1:0]    x01,
    input  wire logic signed [VALUE_BITS-1:0]    x10,
    input  wire logic signed [VALUE_BITS-1:0]    x11,
    input  wire logic [FRAC_BITS:0]              fy,
    input  wire logic [FRAC_BITS:0]              fz,
    output logic signed [VALUE_BITS-1:0]         value
);

    logic signed [VALUE_BITS-1:0] y0;
    logic signed [VALUE_BITS-1:0] y1;

    tiu_lerp #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lerp_y0 (
        .clk (clk),
        .en  (ctl.y_en),
        .a   (x00),
        .b   (x10),
        .f   (fy),
        .y   (y0)
    );

    tiu_lerp #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lerp_y1 (
        .clk (clk),
        .en  (ctl.y_en),
        .a   (x01),
        .b   (x11),
        .f   (fy),
        .y   (y1)
    );

    tiu_lerp #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lerp_z (
        .clk (clk),
        .en  (ctl.z_en),
        .a   (y0),
        .b   (y1),
        .f   (fz),
        .y   (value)
    );

endmodule

`default_nettype wire

>>> hw/rtl/trilinear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// Trilinear interpolator, top level
// An accepted input beat moves through the x-lane, y-merge and z-merge stages.
// Throughput: one beat per cycle unless out_stall holds it; nine pipeline stages.
// Each stage holds only while it is full and the stage after it is blocked.
// Reset empties the pipeline at once; no clearing pass, first beat taken at once.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_interpolator_unit #(
    parameter int VALUE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire logic signed [VALUE_BITS-1:0] corner_x0_y0_z0,
    input  wire logic signed [VALUE_BITS-1:0] corner_x0_y0_z1,
    input  wire logic signed [VALUE_BITS-1:0] corner_x0_y1_z0,
    input  wire logic signed [VALUE_BITS-1:0] corner_x0_y1_z1,
    input  wire logic signed [VALUE_BITS-1:0] corner_x1_y0_z0,
    input  wire logic signed [VALUE_BITS-1:0] corner_x1_y0_z1,
    input  wire logic signed [VALUE_BITS-1:0] corner_x1_y1_z0,
    input  wire logic signed [VALUE_BITS-1:0] corner_x1_y1_z1,
    input  wire logic [FRAC_BITS:0]           frac_x,
    input  wire logic [FRAC_BITS:0]           frac_y,
    input  wire logic [FRAC_BITS:0]           frac_z,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic signed [VALUE_BITS-1:0]      blended_value
);

    localparam int LS  = tiu_pkg::LERP_STAGES;
    localparam int NS  = 3 * LS;
    localparam int NXL = tiu_pkg::X_LANES;
    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [NS:0]                  ready;
    logic [NS-1:0]                valid_reg, valid_next;
    logic [NS-1:0]                valid_in;
    logic [FRAC_BITS:0]           fx_c, fy_c, fz_c;
    logic [FRAC_BITS:0]           fy_dly_reg [LS];
    logic [FRAC_BITS:0]           fz_dly_reg [2*LS];
    logic signed [VALUE_BITS-1:0] lane_a [NXL];
    logic signed [VALUE_BITS-1:0] lane_b [NXL];
    logic signed [VALUE_BITS-1:0] lane_y [NXL];
    tiu_pkg::merge_ctl_t          merge_ctl;

    // clamp fractions to one
    assign fx_c = (frac_x > FRAC_ONE) ? FRAC_ONE : frac_x;
    assign fy_c = (frac_y > FRAC_ONE) ? FRAC_ONE : frac_y;
    assign fz_c = (frac_z > FRAC_ONE) ? FRAC_ONE : frac_z;

    always_comb
    begin
        ready[NS] = !out_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign valid_in   = {valid_reg[NS-2:0], in_valid};
    assign valid_next = (ready[NS-1:0] & valid_in) | (~ready[NS-1:0] & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // fraction delay lines, advancing with their stages
    generate
        for (genvar k = 0; k < LS; k++)
        begin : g_fy_dly
            always_ff @(posedge clk)
            begin
                if (ready[k])
                begin
                    if (k == 0)
                    begin
                        fy_dly_reg[k] <= fy_c;
                    end
                    else
                    begin
                        fy_dly_reg[k] <= fy_dly_reg[(k == 0) ? 0 : k - 1];
                    end
                end
            end
        end
        for (genvar k = 0; k < 2 * LS; k++)
        begin : g_fz_dly
            always_ff @(posedge clk)
            begin
                if (ready[k])
                begin
                    if (k == 0)
                    begin
                        fz_dly_reg[k] <= fz_c;
                    end
                    else
                    begin
                        fz_dly_reg[k] <= fz_dly_reg[(k == 0) ? 0 : k - 1];
                    end
                end
            end
        end
    endgenerate

    assign lane_a[0] = corner_x0_y0_z0;
    assign lane_a[1] = corner_x0_y0_z1;
    assign lane_a[2] = corner_x0_y1_z0;
    assign lane_a[3] = corner_x0_y1_z1;
    assign lane_b[0] = corner_x1_y0_z0;
    assign lane_b[1] = corner_x1_y0_z1;
    assign lane_b[2] = corner_x1_y1_z0;
    assign lane_b[3] = corner_x1_y1_z1;

    generate
        for (genvar i = 0; i < NXL; i++)
        begin : g_x_lane
            tiu_lerp #(
                .VALUE_BITS (VALUE_BITS),
                .FRAC_BITS  (FRAC_BITS)
            ) u_lerp_x (
                .clk (clk),
                .en  (ready[LS-1:0]),
                .a   (lane_a[i]),
                .b   (lane_b[i]),
                .f   (fx_c),
                .y   (lane_y[i])
            );
        end
    endgenerate

    assign merge_ctl.y_en = ready[2*LS-1:LS];
    assign merge_ctl.z_en = ready[NS-1:2*LS];

    tiu_merge #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_merge (
        .clk   (clk),
        .ctl   (merge_ctl),
        .x00   (lane_y[0]),
        .x01   (lane_y[1]),
        .x10   (lane_y[2]),
        .x11   (lane_y[3]),
        .fy    (fy_dly_reg[LS-1]),
        .fz    (fz_dly_reg[2*LS-1]),
        .value (blended_value)
    );

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[NS-1];

endmodule

`default_nettype wire

>>> hw/rtl/tiu_port_checker.sv
// ----------------------------------------------------------------------------
// Trilinear interpolator port checker
// Port-level properties of the handshake and pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trilinear_interpolator_unit_macros.svh"

module tiu_port_checker #(
    parameter int VALUE_BITS = 32
) (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               in_valid,
    input wire                               in_stall,
    input wire                               out_valid,
    input wire                               out_stall,
    input wire logic signed [VALUE_BITS-1:0] blended_value
);

    localparam int DEPTH = 3 * tiu_pkg::LERP_STAGES;

    logic in_beat;
    logic out_held;

    assign in_beat  = in_valid && !in_stall;
    assign out_held = out_valid && out_stall;

    `TIU_ASSERT_NEXT(a_out_hold, out_held, out_valid, "output beat dropped")
    `TIU_ASSERT_NEXT(a_out_stable, out_held, $stable(blended_value), "stalled beat changed")
    `TIU_ASSERT_NOW(a_stall_full, in_stall, out_held, "input stalled with room inside")
    `TIU_ASSERT_NOW(a_latency, $rose(out_valid), $past(in_beat, DEPTH), "no matching input")

endmodule

bind trilinear_interpolator_unit tiu_port_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .blended_value (blended_value)
);

`default_nettype wire
